FILE: rtl/tce_pkg.sv
// ============================================================================
// Taylor cosine evaluator package
// Shared widths, payload types, micro-op codes and the control program.
// ============================================================================
package tce_pkg;

  // Series limits and output scaling.
  localparam int MAX_TERMS = 32;
  localparam int FRAC_BITS = 32;

  // Fixed field widths of the channels.
  localparam int ANGLE_W = 4;
  localparam int TC_W    = 6;
  localparam int OUT_W   = 48;

  localparam logic [TC_W-1:0] TERM_COUNT_RST = TC_W'(20);

  // The angle magnitude reaches 8, so it takes the full angle width unsigned.
  localparam int AX_W = ANGLE_W;

  // Largest x^(2k)/(2k)! over |x| <= 8 is about 416, below 2^9, so the
  // quotient (scaled by 2^(FRAC_BITS+1)) stays below 2^(FRAC_BITS+10).
  localparam int QUOT_W = FRAC_BITS + 10;

  // Numerator 2^(FRAC_BITS+1) * |x|^(2k) with |x| <= 2^(AX_W-1).
  localparam int NUM_RAW_W = FRAC_BITS + 2 + (AX_W - 1) * 2 * (MAX_TERMS - 1);
  localparam int NUM_W     = (NUM_RAW_W > QUOT_W + 1) ? NUM_RAW_W : QUOT_W + 1;

  // Upper bound on the bit length of (2*MAX_TERMS-2)!.
  function automatic int fact_bits(input int m);
    int s;
    s = 1;
    for (int j = 2; j <= m; j++) begin
      s = s + $clog2(j);
    end
    return s;
  endfunction

  localparam int DEN_W = fact_bits(2 * MAX_TERMS - 2);

  // Multiplier operands: |x|^2 and (2k+1)(2k+2).
  localparam int MF_MAX   = (MAX_TERMS > 1) ? (2 * MAX_TERMS - 3) * (2 * MAX_TERMS - 2) : 0;
  localparam int MF_W     = $clog2(MF_MAX + 1);
  localparam int MN_W     = 2 * AX_W - 1;
  localparam int MUL_W    = (MF_W > MN_W) ? MF_W : MN_W;

  localparam int QIDX_W   = $clog2(QUOT_W);
  localparam int MIDX_W   = $clog2(MUL_W);
  localparam int CNT_W    = (QIDX_W > MIDX_W) ? QIDX_W : MIDX_W;
  localparam int LEFT_W   = $clog2(MAX_TERMS + 1);

  // Running sum of rounded terms, each below 2^(QUOT_W-1).
  localparam int SUM_W    = QUOT_W + $clog2(MAX_TERMS);
  localparam int SAT_W    = (SUM_W > OUT_W) ? SUM_W : OUT_W;

  localparam logic signed [SAT_W-1:0] SAT_HI =
    $signed({{(SAT_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}});
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

  // Payload types.
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic        [TC_W-1:0]    term_count_t;
  typedef logic signed [OUT_W-1:0]   cosine_t;

  // Micro-operations executed by the datapath.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_ACCUM,
    OP_MUL_START,
    OP_MUL_STEP,
    OP_MUL_END,
    OP_DONE
  } op_e;

  // Jump conditions.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_TERMS,
    COND_CNT_NZ,
    COND_LAST_TERM
  } cond_e;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // Program addresses.
  localparam pc_t PC_INIT      = PC_W'(0);
  localparam pc_t PC_CHECK     = PC_W'(1);
  localparam pc_t PC_DIV_START = PC_W'(2);
  localparam pc_t PC_DIV_STEP  = PC_W'(3);
  localparam pc_t PC_ACCUM     = PC_W'(4);
  localparam pc_t PC_MUL_START = PC_W'(5);
  localparam pc_t PC_MUL_STEP  = PC_W'(6);
  localparam pc_t PC_MUL_END   = PC_W'(7);
  localparam pc_t PC_DONE      = PC_W'(8);

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
    logic  fin;
  } ctrl_t;

  typedef struct packed {
    logic cnt_nz;
    logic no_terms;
    logic last_term;
  } dp_status_t;

  // Control store: one word per program step.
  function automatic ctrl_t ucode_word(input pc_t pc);
    ctrl_t w;
    unique case (pc)
      PC_INIT:      w = '{op: OP_INIT,      cond: COND_NEVER,     target: PC_INIT,      fin: 1'b0};
      PC_CHECK:     w = '{op: OP_NOP,       cond: COND_NO_TERMS,  target: PC_DONE,      fin: 1'b0};
      PC_DIV_START: w = '{op: OP_DIV_START, cond: COND_NEVER,     target: PC_INIT,      fin: 1'b0};
      PC_DIV_STEP:  w = '{op: OP_DIV_STEP,  cond: COND_CNT_NZ,    target: PC_DIV_STEP,  fin: 1'b0};
      PC_ACCUM:     w = '{op: OP_ACCUM,     cond: COND_LAST_TERM, target: PC_DONE,      fin: 1'b0};
      PC_MUL_START: w = '{op: OP_MUL_START, cond: COND_NEVER,     target: PC_INIT,      fin: 1'b0};
      PC_MUL_STEP:  w = '{op: OP_MUL_STEP,  cond: COND_CNT_NZ,    target: PC_MUL_STEP,  fin: 1'b0};
      PC_MUL_END:   w = '{op: OP_MUL_END,   cond: COND_ALWAYS,    target: PC_DIV_START, fin: 1'b0};
      PC_DONE:      w = '{op: OP_DONE,      cond: COND_NEVER,     target: PC_DONE,      fin: 1'b1};
      default:      w = '{op: OP_NOP,       cond: COND_ALWAYS,    target: PC_DONE,      fin: 1'b0};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/tce_angle_if.sv
// ============================================================================
// Angle channel
// Valid/ready channel that carries one input angle per transaction.
// ============================================================================
interface tce_angle_if;
  import tce_pkg::*;

  logic   valid;
  logic   ready;
  angle_t angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

FILE: rtl/tce_cosine_if.sv
// ============================================================================
// Cosine result channel
// Valid/ready channel that carries one fixed-point cosine per transaction.
// ============================================================================
interface tce_cosine_if;
  import tce_pkg::*;

  logic    valid;
  logic    ready;
  cosine_t cosine_value;

  modport source (output valid, output cosine_value, input ready);
  modport sink   (input valid, input cosine_value, output ready);
endinterface

FILE: rtl/tce_cfg_if.sv
// ============================================================================
// Configuration channel
// Valid/ready write channel for the term count register.
// ============================================================================
interface tce_cfg_if;
  import tce_pkg::*;

  logic        valid;
  logic        ready;
  term_count_t term_count;

  modport source (output valid, output term_count, input ready);
  modport sink   (input valid, input term_count, output ready);
endinterface

FILE: rtl/taylor_cosine_evaluator.sv
// ============================================================================
// Taylor cosine evaluator
// For each angle transaction, one transaction with the Maclaurin partial sum of
// cosine in signed Q16.32, each term rounded half up and the sum saturated.
// A microcoded sequencer works through the terms one at a time: it forms
// |x|^(2k) * 2^33 and (2k)! exactly, divides them with a one-bit-per-cycle
// restoring divider, rounds and accumulates, then scales both operands for
// the next term with a shift-and-add multiplier. The effective term count
// is term_count limited to 32; each term runs the 42-step divide loop, and
// each term but the last also runs the 12-step multiply loop.
// Only one item is in flight at a time. A finished result sits in an output
// register, and a new angle is accepted while it waits to be taken. The
// term_count register resets to 20 and is always ready; write it only while
// the block is idle.
// ============================================================================
module taylor_cosine_evaluator (
  input logic          clk_i,
  input logic          rst_ni,
  tce_angle_if.sink    angle_if,
  tce_cosine_if.source cosine_if,
  tce_cfg_if.sink      cfg_if
);
  import tce_pkg::*;

  term_count_t         term_count_q;
  logic                out_valid_q;
  cosine_t             out_data_q;

  logic                in_accept;
  logic                hold;
  logic                done;
  logic                busy;
  op_e                 op;
  dp_status_t          status;
  cosine_t             result;

  // Configuration writes land directly in the register.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= TERM_COUNT_RST;
    end else if (cfg_if.valid) begin
      term_count_q <= cfg_if.term_count;
    end
  end

  // An angle is taken whenever the sequencer is not working on one.
  assign angle_if.ready = ~busy;
  assign in_accept      = angle_if.valid & ~busy;

  // The last program step waits while an older result is still unclaimed.
  assign hold = out_valid_q & ~cosine_if.ready;

  tce_ucode_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_accept),
    .hold_i   (hold),
    .status_i (status),
    .op_o     (op),
    .done_o   (done),
    .busy_o   (busy)
  );

  tce_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_accept),
    .angle_i      (angle_if.angle),
    .term_count_i (term_count_q),
    .op_i         (op),
    .status_o     (status),
    .result_o     (result)
  );

  // Output register: loaded when the program finishes, cleared when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (cosine_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q <= result;
    end
  end

  assign cosine_if.valid        = out_valid_q;
  assign cosine_if.cosine_value = out_data_q;

  // An accepted angle always starts the program.
  a_start_runs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> busy)
    else $error("accepted angle did not start the sequencer");

  // A finished result never overwrites one that is still waiting.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (!out_valid_q || cosine_if.ready))
    else $error("result register overwritten");

  // A completion always presents a result in the next cycle.
  a_done_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_q)
    else $error("completed item produced no result");

endmodule

FILE: rtl/tce_ucode_seq.sv
// ============================================================================
// Microcode sequencer
// Step counter over the control store with conditional jumps.
// ============================================================================
module tce_ucode_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                hold_i,
  input  tce_pkg::dp_status_t status_i,
  output tce_pkg::op_e        op_o,
  output logic                done_o,
  output logic                busy_o
);
  import tce_pkg::*;

  pc_t   pc_q, pc_d;
  logic  busy_q, busy_d;
  ctrl_t ctrl;
  logic  taken;

  always_comb begin
    ctrl = ucode_word(pc_q);
    case (ctrl.cond)
      COND_ALWAYS:    taken = 1'b1;
      COND_NO_TERMS:  taken = status_i.no_terms;
      COND_CNT_NZ:    taken = status_i.cnt_nz;
      COND_LAST_TERM: taken = status_i.last_term;
      default:        taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = PC_INIT;
      end
    end else if (ctrl.fin) begin
      // The final step waits here until the result register is free.
      if (!hold_i) begin
        busy_d = 1'b0;
      end
    end else begin
      pc_d = taken ? ctrl.target : pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= PC_INIT;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  assign op_o   = busy_q ? ctrl.op : OP_NOP;
  assign done_o = busy_q & ctrl.fin & ~hold_i;
  assign busy_o = busy_q;

  // The program counter never leaves the program while an item is in flight.
  a_pc_in_program : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= PC_DONE))
    else $error("sequencer left the program");

endmodule

FILE: rtl/tce_datapath.sv
// ============================================================================
// Series datapath
// Exact numerator and factorial, restoring divider, shift-and-add multiplier and saturating signed accumulator.
// ============================================================================
module tce_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  tce_pkg::angle_t      angle_i,
  input  tce_pkg::term_count_t term_count_i,
  input  tce_pkg::op_e         op_i,
  output tce_pkg::dp_status_t  status_o,
  output tce_pkg::cosine_t     result_o
);
  import tce_pkg::*;

  // Control state.
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LEFT_W-1:0] left_q, left_d;
  logic [LEFT_W-1:0] k_q, k_d;

  // Arithmetic payload.
  logic [AX_W-1:0]   ax_q;
  logic [NUM_W-1:0]  num_q, num_d, num_acc_q, num_acc_d;
  logic [DEN_W-1:0]  den_q, den_d, den_acc_q, den_acc_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [MUL_W-1:0]  mn_q, mn_d, mf_q, mf_d;

  logic [LEFT_W-1:0] n_eff;
  logic [QUOT_W-1:0] num_low;
  logic [DEN_W:0]    shifted;
  logic [DEN_W+1:0]  diff;
  logic [QUOT_W:0]   rnd;
  logic [SUM_W-1:0]  term_ext;
  logic [MUL_W-1:0]  f_lo, f_hi, ax_w;
  logic [MIDX_W-1:0] midx;
  logic signed [SAT_W-1:0] sum_ext;

  assign n_eff = (term_count_i > TC_W'(MAX_TERMS)) ? LEFT_W'(MAX_TERMS)
                                                   : LEFT_W'(term_count_i);

  always_comb begin
    num_low  = num_q[QUOT_W-1:0];
    shifted  = {rem_q, num_low[cnt_q[QIDX_W-1:0]]};
    diff     = {1'b0, shifted} - {2'b00, den_q};
    rnd      = ({1'b0, quot_q} + (QUOT_W + 1)'(1)) >> 1;
    term_ext = SUM_W'(rnd[QUOT_W-1:0]);
    f_lo     = MUL_W'({k_q, 1'b1});
    f_hi     = f_lo + MUL_W'(1);
    ax_w     = MUL_W'(ax_q);
    midx     = cnt_q[MIDX_W-1:0];
  end

  always_comb begin
    cnt_d     = cnt_q;
    left_d    = left_q;
    k_d       = k_q;
    num_d     = num_q;
    num_acc_d = num_acc_q;
    den_d     = den_q;
    den_acc_d = den_acc_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    sum_d     = sum_q;
    mn_d      = mn_q;
    mf_d      = mf_q;
    unique case (op_i) inside
      OP_INIT: begin
        num_d  = NUM_W'(1) << (FRAC_BITS + 1);
        den_d  = DEN_W'(1);
        sum_d  = '0;
        k_d    = '0;
        left_d = n_eff;
      end
      OP_DIV_START: begin
        // The high part of the numerator is already below the divisor.
        rem_d  = DEN_W'(num_q >> QUOT_W);
        quot_d = '0;
        cnt_d  = CNT_W'(QUOT_W - 1);
      end
      OP_DIV_STEP: begin
        if (!diff[DEN_W+1]) begin
          rem_d = diff[DEN_W-1:0];
        end else begin
          rem_d = shifted[DEN_W-1:0];
        end
        quot_d = {quot_q[QUOT_W-2:0], ~diff[DEN_W+1]};
        cnt_d  = cnt_q - CNT_W'(1);
      end
      OP_ACCUM: begin
        // Odd terms carry a negative sign.
        sum_d  = k_q[0] ? sum_q - term_ext : sum_q + term_ext;
        left_d = left_q - LEFT_W'(1);
      end
      OP_MUL_START: begin
        num_acc_d = '0;
        den_acc_d = '0;
        mn_d      = ax_w * ax_w;
        mf_d      = f_lo * f_hi;
        cnt_d     = CNT_W'(MUL_W - 1);
      end
      OP_MUL_STEP: begin
        num_acc_d = {num_acc_q[NUM_W-2:0], 1'b0} + (mn_q[midx] ? num_q : '0);
        den_acc_d = {den_acc_q[DEN_W-2:0], 1'b0} + (mf_q[midx] ? den_q : '0);
        cnt_d     = cnt_q - CNT_W'(1);
      end
      OP_MUL_END: begin
        num_d = num_acc_q;
        den_d = den_acc_q;
        k_d   = k_q + LEFT_W'(1);
      end
      OP_NOP, OP_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      left_q <= '0;
      k_q    <= '0;
    end else begin
      cnt_q  <= cnt_d;
      left_q <= left_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ax_q <= angle_i[ANGLE_W-1] ? AX_W'(~angle_i + ANGLE_W'(1)) : AX_W'(angle_i);
    end
    num_q     <= num_d;
    num_acc_q <= num_acc_d;
    den_q     <= den_d;
    den_acc_q <= den_acc_d;
    rem_q     <= rem_d;
    quot_q    <= quot_d;
    sum_q     <= sum_d;
    mn_q      <= mn_d;
    mf_q      <= mf_d;
  end

  // Saturate the sum to the output range.
  always_comb begin
    sum_ext = SAT_W'($signed(sum_q));
    if (sum_ext > SAT_HI) begin
      result_o = OUT_W'(SAT_HI);
    end else if (sum_ext < SAT_LO) begin
      result_o = OUT_W'(SAT_LO);
    end else begin
      result_o = OUT_W'(sum_ext);
    end
  end

  assign status_o = '{cnt_nz:    (cnt_q != '0),
                      no_terms:  (left_q == '0),
                      last_term: (left_q == LEFT_W'(1))};

endmodule

FILE: dv/tce_cosine_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// Taylor cosine result checker
// Watches the angle, cosine and configuration channels, predicts the partial
// cosine sum for every accepted angle and compares it with each result.
// ============================================================================
module tce_cosine_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  tce_angle_if  angle_if,
  tce_cosine_if cosine_if,
  tce_cfg_if    cfg_if,
  input  logic  drain_done_i,
  output int    checked_o,
  output int    errors_o
);
  import tce_pkg::*;

  localparam longint COS_HI = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint COS_LO = -COS_HI - 1;

  typedef struct packed {
    angle_t      angle;
    term_count_t terms;
    cosine_t     cosine;
  } cosine_due_t;

  cosine_due_t cosine_due [$];
  term_count_t term_count_q = TERM_COUNT_RST;
  int          checked_q = 0;
  int          mismatches = 0;
  bit          leftover_done = 1'b0;

  assign checked_o = checked_q;
  assign errors_o  = mismatches;

  task automatic report_mismatch(input string msg);
    $display("%0t ns  cosine check: %s", $time, msg);
    mismatches++;
  endtask

  // Each term is formed exactly as x^(2k) * 2^(FRAC_BITS+1) / (2k)!, so the
  // quotient carries one extra fraction bit that is used to round half up.
  function automatic cosine_t cosine_series(input angle_t angle, input term_count_t terms);
    logic [319:0] numer;
    logic [319:0] denom;
    logic [319:0] quot;
    logic [3:0]   mag;
    longint       tmag;
    longint       total;
    int           n;
    mag   = (angle < 0) ? 4'(-angle) : 4'(angle);
    numer = 320'd1 << (FRAC_BITS + 1);
    denom = 320'd1;
    total = 0;
    n     = (terms > MAX_TERMS) ? MAX_TERMS : int'(terms);
    for (int k = 0; k < n; k++) begin
      quot = numer / denom;
      tmag = longint'((quot[63:0] + 64'd1) >> 1);
      if (k % 2 == 1) begin
        total = total - tmag;
      end else begin
        total = total + tmag;
      end
      numer = numer * mag * mag;
      denom = denom * 320'(2 * k + 1) * 320'(2 * k + 2);
    end
    if (total > COS_HI) begin
      total = COS_HI;
    end
    if (total < COS_LO) begin
      total = COS_LO;
    end
    return cosine_t'(total);
  endfunction

  always @(posedge clk_i) begin
    cosine_due_t due;
    if (!rst_ni) begin
      term_count_q = TERM_COUNT_RST;
      cosine_due.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        term_count_q = cfg_if.term_count;
      end
      // The result is matched before a new angle is queued, so a result can
      // never be paired with the angle accepted on the same edge.
      if (cosine_if.valid && cosine_if.ready) begin
        if (cosine_due.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no angle waiting",
                                    cosine_if.cosine_value));
        end else begin
          due = cosine_due.pop_front();
          if (cosine_if.cosine_value !== due.cosine) begin
            report_mismatch($sformatf("angle %0d terms %0d: cosine %0d, predicted %0d",
                                      due.angle, due.terms, cosine_if.cosine_value,
                                      due.cosine));
          end
        end
        checked_q <= checked_q + 1;
      end
      if (angle_if.valid && angle_if.ready) begin
        due.angle  = angle_if.angle;
        due.terms  = term_count_q;
        due.cosine = cosine_series(angle_if.angle, term_count_q);
        cosine_due.push_back(due);
      end
      if (drain_done_i && !leftover_done) begin
        leftover_done = 1'b1;
        if (cosine_due.size() != 0) begin
          report_mismatch($sformatf("%0d predicted results never arrived",
                                    cosine_due.size()));
        end
      end
    end
  end

endmodule

FILE: dv/taylor_cosine_evaluator_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Taylor cosine evaluator testbench
// Drives angles through the block under several term counts, with random
// idling on both channels and long output stalls, and leaves prediction and
// comparison to the checker instantiated beside the block.
// ============================================================================
module taylor_cosine_evaluator_tb;
  import tce_pkg::*;

  logic clk;
  logic rst_n;
  logic calm;
  logic drain_done;

  // Number of angle transactions the block has accepted so far. Only the
  // stimulus process changes it.
  int sent = 0;
  int checked;
  int errors;

  // Term counts used by the random phases. Large counts make an item slow,
  // so the phases that use them carry fewer items. The value 63 lies above
  // the series limit and must behave like 32.
  term_count_t phase_tc [10] = '{6'd1, 6'd63, 6'd2, 6'd3, 6'd0,
                                 6'd5, 6'd7, 6'd32, 6'd10, 6'd4};

  tce_angle_if  angle_ch ();
  tce_cosine_if cosine_ch ();
  tce_cfg_if    cfg_ch ();

  taylor_cosine_evaluator uut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .angle_if  (angle_ch),
    .cosine_if (cosine_ch),
    .cfg_if    (cfg_ch)
  );

  tce_cosine_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .angle_if     (angle_ch),
    .cosine_if    (cosine_ch),
    .cfg_if       (cfg_ch),
    .drain_done_i (drain_done),
    .checked_o    (checked),
    .errors_o     (errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offers one angle, after a random number of idle cycles unless the
  // current phase runs without idling. Valid is only ever assigned once per
  // edge, so back-to-back transactions keep it high without a glitch.
  task automatic send_angle(input angle_t angle);
    while (!calm && $urandom_range(99) < 35) begin
      angle_ch.valid <= 1'b0;
      @(posedge clk);
    end
    angle_ch.valid <= 1'b1;
    angle_ch.angle <= angle;
    @(posedge clk);
    while (!angle_ch.ready) begin
      @(posedge clk);
    end
    sent++;
  endtask

  // Waits until every accepted angle has produced its checked result. The
  // checker count is registered, so this never ends too early.
  task automatic drain_results();
    angle_ch.valid <= 1'b0;
    while (checked < sent) begin
      @(posedge clk);
    end
  endtask

  // The block is idle whenever this is called: the last result has been
  // taken and every item yields exactly one result.
  task automatic write_term_count(input term_count_t terms);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.term_count <= terms;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int count;
    angle_ch.valid    <= 1'b0;
    angle_ch.angle    <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.term_count <= '0;
    rst_n             <= 1'b0;
    calm              <= 1'b0;
    drain_done        <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Under the reset term count every angle is sent once,
    // which covers both extremes and the zero angle.
    for (int a = -8; a <= 7; a++) begin
      send_angle(angle_t'(a));
    end
    drain_results();

    // Zero terms must give zero regardless of the angle.
    write_term_count(term_count_t'(0));
    send_angle(angle_t'(-8));
    send_angle(angle_t'(0));
    send_angle(angle_t'(7));
    drain_results();

    // A term count above the series limit is clamped to the limit.
    write_term_count(term_count_t'(63));
    send_angle(angle_t'(-8));
    send_angle(angle_t'(0));
    send_angle(angle_t'(7));
    drain_results();

    // Random part: one phase per term count. The fourth phase runs with no
    // idling on either side.
    for (int p = 0; p < 10; p++) begin
      write_term_count(phase_tc[p]);
      calm  <= (p == 3);
      count = (phase_tc[p] >= 16) ? 15 : 55;
      repeat (count) begin
        send_angle(angle_t'($urandom_range(15)));
      end
      drain_results();
    end
    calm <= 1'b0;

    // Let the longest item time pass to catch any stray result.
    repeat (2000) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (errors == 0) begin
      $display("taylor_cosine_evaluator_tb: clean");
    end else begin
      $display("taylor_cosine_evaluator_tb: errors");
    end
    $finish;
  end

  // Result receiver. It takes results with random stalls, and after the
  // 150th and the 400th result it holds off for a long stretch while the
  // sender keeps offering angles, so the output register fills and the
  // block has to stall its input.
  initial begin : result_sink
    int hold_left;
    int taken;
    int next_hold;
    hold_left = 0;
    taken     = 0;
    next_hold = 150;
    cosine_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cosine_ch.valid && cosine_ch.ready) begin
        taken++;
      end
      if (hold_left == 0 && taken >= next_hold) begin
        hold_left = 1500;
        next_hold = next_hold + 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        cosine_ch.ready <= 1'b0;
      end else begin
        cosine_ch.ready <= calm || ($urandom_range(99) >= 35);
      end
    end
  end

  // Watchdog timeout, several times the length of the slowest run.
  initial begin : watchdog
    #48000000;
    $display("taylor_cosine_evaluator_tb: errors");
    $finish;
  end

endmodule
